[rtl/kbh_pkg.sv]
// kbh_pkg: shared types and constants of the key bucket hash block
package kbh_pkg;

    // field and state widths
    localparam int HASH_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int POS_W    = 7;
    localparam int OPND_W   = 16;
    localparam int CNT_W    = 5;

    // position limits
    localparam logic [POS_W-1:0] POS_MAX       = 7'd127;
    localparam logic [POS_W-1:0] MAX_KEY_BYTES = 7'd64;

    // configuration
    localparam logic [HASH_W-1:0] TABLE_SIZE_RESET = 32'd1024;
    localparam int                PADDR_W          = 3;
    localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = 3'd0;

    // queue between hash front and modulo back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // hash front sequencer
    typedef enum logic [1:0] {
        F_IDLE,
        F_UPD,
        F_FIN
    } t_front_state;

    // pending update of the running hash
    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_MUL
    } t_op;

    // modulo unit sequencer
    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_DONE
    } t_mod_state;

    // one finished hash travelling to the queue
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } t_hash_beat;

endpackage

[rtl/key_bucket_hash_top.sv]
// key_bucket_hash_top: byte-serial key hash to bucket index, with config port
//
// channel   direction  handshake                    beat
// input     in         push / full                  key_byte, key_length, last_byte
// result    out        empty / pop                  bucket_index
// config    in         psel, penable, pwrite, pready table_size at byte address 0
//
// a key byte is taken in F_IDLE and worked in F_UPD (adder or 32x16 multiply), the last
// byte also passes F_FIN (the multiply by the length, held while the queue is full)
// each bucket index passes M_RUN in the modulo unit (one restoring step a cycle, skipped
// when table_size is 0), which runs behind a queue while the front takes the next key
// reset is synchronous: hash, position, queue and result valid are cleared,
// table_size returns to 1024
// full is high while a byte is worked or a final hash waits on a full queue; a result
// waiting on the output does not block the next key
module key_bucket_hash_top
    import kbh_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               push,
    output logic               full,
    input  logic [BYTE_W-1:0]  i_key_byte,
    input  logic [LEN_W-1:0]   i_key_length,
    input  logic               i_last_byte,
    // result channel
    output logic               empty,
    input  logic               pop,
    output logic [HASH_W-1:0]  o_bucket_index,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [HASH_W-1:0] r_table_size;
    t_hash_beat        q_wr;
    logic              q_full;
    logic              q_empty;
    logic              q_rd;
    logic [HASH_W-1:0] q_data;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TABLE_SIZE) ? r_table_size : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_TABLE_SIZE) begin
            r_table_size <= pwdata;
        end
    end

    // hash front
    kbh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_key_byte   (i_key_byte),
        .i_key_length (i_key_length),
        .i_last_byte  (i_last_byte),
        .i_q_full     (q_full),
        .o_q_wr       (q_wr)
    );

    // queue of final hashes
    kbh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // modulo back end
    kbh_mod u_mod (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_data),
        .o_q_rd         (q_rd),
        .i_table_size   (r_table_size),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_bucket_index (o_bucket_index)
    );

endmodule

[rtl/kbh_front.sv]
// kbh_front: takes key bytes and keeps the running hash, pushes each final hash
module kbh_front
    import kbh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic [LEN_W-1:0]  i_key_length,
    input  logic              i_last_byte,
    input  logic              i_q_full,
    output t_hash_beat        o_q_wr
);

    t_front_state      r_state, n_state;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [POS_W-1:0]  r_pos, n_pos;
    t_op               r_op, n_op;
    logic [OPND_W-1:0] r_operand, n_operand;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;

    logic                 accept;
    logic                 in_range;
    logic [14:0]          prod_bp;
    logic [14:0]          prod_bl;
    logic [OPND_W-1:0]    factor;
    logic [47:0]          upd_full;
    logic [38:0]          fin_full;

    assign accept = i_push && !o_full;

    // classify the byte: which update it makes
    always_comb begin
        in_range  = (r_pos < i_key_length) && (r_pos < MAX_KEY_BYTES);
        prod_bp   = {7'b0, i_key_byte} * {8'b0, r_pos};
        prod_bl   = {7'b0, i_key_byte} * {8'b0, i_key_length};
        factor    = {1'b0, prod_bp} + OPND_W'(i_key_length) + OPND_W'(r_pos);
        n_op      = OP_NONE;
        n_operand = '0;
        if (in_range) begin
            if (r_pos == '0) begin
                n_op      = OP_ADD;
                n_operand = OPND_W'(i_key_byte);
            end else if (r_pos == POS_W'(1)) begin
                n_op      = OP_ADD;
                n_operand = {1'b0, prod_bl};
            end else begin
                n_op      = OP_MUL;
                n_operand = factor;
            end
        end
    end

    // hash arithmetic: the update multiply and the final multiply by the length
    assign upd_full = r_hash * r_operand;
    assign fin_full = r_hash * r_len;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_UPD;
            end
            F_UPD: begin
                n_state = r_last ? F_FIN : F_IDLE;
            end
            F_FIN: begin
                if (!i_q_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        o_full      = (r_state != F_IDLE);
        o_q_wr.valid = (r_state == F_FIN) && !i_q_full;
        o_q_wr.hash  = fin_full[HASH_W-1:0];
        n_hash      = r_hash;
        n_pos       = r_pos;
        unique case (r_state)
            F_IDLE: begin
                if (accept && (r_pos < POS_MAX)) n_pos = r_pos + POS_W'(1);
            end
            F_UPD: begin
                case (r_op)
                    OP_ADD:  n_hash = r_hash + HASH_W'(r_operand);
                    OP_MUL:  n_hash = upd_full[HASH_W-1:0];
                    default: n_hash = r_hash;
                endcase
            end
            F_FIN: begin
                if (!i_q_full) begin
                    n_hash = '0;
                    n_pos  = '0;
                end
            end
            default: ;
        endcase
    end

    // control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_hash  <= '0;
            r_pos   <= '0;
            r_op    <= OP_NONE;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_pos   <= n_pos;
            if (accept) r_op <= n_op;
        end
    end

    // captured byte details
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_operand <= n_operand;
            r_len     <= i_key_length;
            r_last    <= i_last_byte;
        end
    end

endmodule

[rtl/kbh_fifo.sv]
// kbh_fifo: short queue of final hashes between front and modulo unit
module kbh_fifo
    import kbh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hash_beat        i_wr,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_empty,
    output logic [HASH_W-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    logic [HASH_W-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;
    logic               wr_en, rd_en;

    assign o_full  = (r_count == CNT_W_Q'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr.valid && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr_ptr] <= i_wr.hash;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) r_count <= r_count + CNT_W_Q'(1);
            else if (rd_en && !wr_en) r_count <= r_count - CNT_W_Q'(1);
        end
    end

endmodule

[rtl/kbh_mod.sv]
// kbh_mod: bit-serial remainder of each hash by the table size, with result register
module kbh_mod
    import kbh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  logic [HASH_W-1:0] i_q_data,
    output logic              o_q_rd,
    input  logic [HASH_W-1:0] i_table_size,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [HASH_W-1:0] o_bucket_index
);

    t_mod_state        r_state, n_state;
    logic [HASH_W-1:0] r_num;
    logic [HASH_W:0]   r_rem;
    logic [HASH_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out;

    logic              take;
    logic              load_out;
    logic              out_free;
    logic [HASH_W:0]   shifted;
    logic [HASH_W:0]   step_rem;

    // one restoring step per cycle
    always_comb begin
        shifted  = {r_rem[HASH_W-1:0], r_num[HASH_W-1]};
        step_rem = (shifted >= {1'b0, r_div}) ? shifted - {1'b0, r_div} : shifted;
    end

    assign out_free = !r_out_valid || i_pop;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE: begin
                if (!i_q_empty) n_state = (i_table_size == '0) ? M_DONE : M_RUN;
            end
            M_RUN: begin
                if (r_cnt == CNT_W'(HASH_W - 1)) n_state = M_DONE;
            end
            M_DONE: begin
                if (out_free) n_state = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        take     = (r_state == M_IDLE) && !i_q_empty;
        load_out = (r_state == M_DONE) && out_free;
        o_q_rd   = take;
        o_empty  = !r_out_valid;
        o_bucket_index = r_out;
    end

    // sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_num <= i_q_data;
            r_div <= i_table_size;
            r_cnt <= '0;
            r_rem <= (i_table_size == '0) ? {1'b0, i_q_data} : '0;
        end else if (r_state == M_RUN) begin
            r_num <= {r_num[HASH_W-2:0], 1'b0};
            r_rem <= step_rem;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (load_out) r_out <= r_rem[HASH_W-1:0];
    end

endmodule
